[design/bnc_pkg.sv]
// Shared types, character codes and decode functions for the bracket nesting checker.
// Used by bnc_stack, bnc_score_acc and bracket_nesting_checker. No dependencies.
`default_nettype none

package bnc_pkg;

    localparam int CHAR_W          = 8;
    localparam int ERR_W           = 15;
    localparam int SCORE_W         = 38;
    localparam int DEF_STACK_DEPTH = 16;

    typedef logic [1:0] kind_t;

    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_CORRUPTED  = 2'd2,
        ST_OVERFLOW   = 2'd3
    } status_t;

    // write port of the bracket stack
    typedef struct packed {
        logic  en;
        kind_t kind;
    } stk_wr_t;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LSQ    = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RSQ    = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;

    localparam kind_t KIND_PAREN = 2'd0;
    localparam kind_t KIND_SQ    = 2'd1;
    localparam kind_t KIND_BRACE = 2'd2;
    localparam kind_t KIND_ANGLE = 2'd3;

    localparam logic [ERR_W-1:0] SCORE_PAREN = 15'd3;
    localparam logic [ERR_W-1:0] SCORE_SQ    = 15'd57;
    localparam logic [ERR_W-1:0] SCORE_BRACE = 15'd1197;
    localparam logic [ERR_W-1:0] SCORE_ANGLE = 15'd25137;

    function automatic logic is_opener(input logic [CHAR_W-1:0] ch);
        return (ch == CH_LPAREN) || (ch == CH_LSQ) || (ch == CH_LBRACE) || (ch == CH_LANGLE);
    endfunction

    function automatic logic is_closer(input logic [CHAR_W-1:0] ch);
        return (ch == CH_RPAREN) || (ch == CH_RSQ) || (ch == CH_RBRACE) || (ch == CH_RANGLE);
    endfunction

    function automatic kind_t opener_kind(input logic [CHAR_W-1:0] ch);
        kind_t k;
        case (ch)
            CH_LPAREN: k = KIND_PAREN;
            CH_LSQ:    k = KIND_SQ;
            CH_LBRACE: k = KIND_BRACE;
            CH_LANGLE: k = KIND_ANGLE;
            default:   k = KIND_PAREN;
        endcase
        return k;
    endfunction

    function automatic kind_t closer_kind(input logic [CHAR_W-1:0] ch);
        kind_t k;
        case (ch)
            CH_RPAREN: k = KIND_PAREN;
            CH_RSQ:    k = KIND_SQ;
            CH_RBRACE: k = KIND_BRACE;
            CH_RANGLE: k = KIND_ANGLE;
            default:   k = KIND_PAREN;
        endcase
        return k;
    endfunction

    function automatic logic [ERR_W-1:0] illegal_score(input logic [CHAR_W-1:0] ch);
        logic [ERR_W-1:0] s;
        case (ch)
            CH_RPAREN: s = SCORE_PAREN;
            CH_RSQ:    s = SCORE_SQ;
            CH_RBRACE: s = SCORE_BRACE;
            CH_RANGLE: s = SCORE_ANGLE;
            default:   s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[design/bnc_stack.sv]
// Bracket stack storage: one write port, one read port at a selected address.
// Depends on bnc_pkg.
`default_nettype none

module bnc_stack
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire stk_wr_t          wr,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [IDX_W-1:0] rd_addr,
    output kind_t                 rd_kind
);

    // contents are only read below the fill level, so no reset
    kind_t entry_reg [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            entry_reg[wr_addr] <= wr.kind;
        end
    end

    assign rd_kind = entry_reg[rd_addr];

endmodule

`default_nettype wire

[design/bnc_score_acc.sv]
// Completion score accumulator: acc <= acc*5 + kind + 1, one stack entry per step.
// Depends on bnc_pkg.
`default_nettype none

module bnc_score_acc
    import bnc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clr,
    input  wire logic               step,
    input  wire kind_t              kind,
    output logic [SCORE_W-1:0]      acc
);

    logic [SCORE_W-1:0] acc_reg;
    logic [SCORE_W-1:0] acc_next;
    logic [SCORE_W-1:0] times5;

    // x5 as shift and add; wraps modulo 2^38
    assign times5 = (acc_reg << 2) + acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (clr)
        begin
            acc_next = '0;
        end
        else if (step)
        begin
            acc_next = times5 + SCORE_W'(kind) + SCORE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[design/bracket_nesting_checker.sv]
// Bracket nesting checker. Characters are taken one per cycle on the item channel while
// the block is idle; a character word gives no result. A line-end word gives one result:
// complete, corrupted or overflowed lines pass through the emit state before the next word
// is taken; an incomplete line with N open brackets first passes through the walk state, as
// the stack is walked from the top one entry per cycle through the shared multiply-by-five
// accumulator. The result sits in an output register, so characters of the next line flow in
// while it waits; a line end that finds the previous result still held waits in the emit
// state until it drains. Depends on bnc_pkg, bnc_stack and bnc_score_acc.
`default_nettype none

module bracket_nesting_checker
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic [CHAR_W-1:0]   char_code,
    input  wire logic                line_end,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [1:0]               status,
    output logic [ERR_W-1:0]         error_score,
    output logic [SCORE_W-1:0]       completion_score,
    output logic [CHAR_W-1:0]        offending_char
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t              state_reg,    state_next;
    logic [LVL_W-1:0]    level_reg,    level_next;
    logic                corrupt_reg,  corrupt_next;
    logic                overflow_reg, overflow_next;
    logic [CHAR_W-1:0]   bad_reg,      bad_next;
    logic [LVL_W-1:0]    walk_cnt_reg, walk_cnt_next;
    status_t             res_status_reg, res_status_next;
    logic [ERR_W-1:0]    res_err_reg,  res_err_next;
    logic [CHAR_W-1:0]   res_bad_reg,  res_bad_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_status_reg;
    logic [ERR_W-1:0]    out_err_reg;
    logic [SCORE_W-1:0]  out_comp_reg;
    logic [CHAR_W-1:0]   out_bad_reg;

    logic                accept;
    logic                load_out;
    logic                acc_clr;
    logic                acc_step;
    logic [SCORE_W-1:0]  acc;
    stk_wr_t             stk_wr;
    kind_t               top_kind;
    logic [LVL_W-1:0]    level_dec;
    logic [LVL_W-1:0]    walk_dec;
    logic [IDX_W-1:0]    rd_addr;
    logic                ch_open;
    logic                ch_close;
    kind_t               ch_open_kind;
    kind_t               ch_close_kind;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    assign ch_open       = is_opener(char_code);
    assign ch_close      = is_closer(char_code);
    assign ch_open_kind  = opener_kind(char_code);
    assign ch_close_kind = closer_kind(char_code);

    assign level_dec = level_reg - LVL_ONE;
    assign walk_dec  = walk_cnt_reg - LVL_ONE;
    // walk pointer in the walk state, top of stack otherwise
    assign rd_addr   = (state_reg == S_WALK) ? walk_dec[IDX_W-1:0] : level_dec[IDX_W-1:0];

    bnc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .IDX_W       (IDX_W)
    ) u_stack (
        .clk     (clk),
        .wr      (stk_wr),
        .wr_addr (level_reg[IDX_W-1:0]),
        .rd_addr (rd_addr),
        .rd_kind (top_kind)
    );

    bnc_score_acc u_score (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (acc_clr),
        .step  (acc_step),
        .kind  (top_kind),
        .acc   (acc)
    );

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        corrupt_next    = corrupt_reg;
        overflow_next   = overflow_reg;
        bad_next        = bad_reg;
        walk_cnt_next   = walk_cnt_reg;
        res_status_next = res_status_reg;
        res_err_next    = res_err_reg;
        res_bad_next    = res_bad_reg;
        stk_wr.en       = 1'b0;
        stk_wr.kind     = ch_open_kind;
        acc_clr         = 1'b0;
        acc_step        = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && line_end)
                begin
                    acc_clr       = 1'b1;
                    walk_cnt_next = level_reg;
                    res_err_next  = '0;
                    res_bad_next  = '0;
                    if (corrupt_reg)
                    begin
                        res_status_next = ST_CORRUPTED;
                        res_err_next    = illegal_score(bad_reg);
                        res_bad_next    = bad_reg;
                        state_next      = S_EMIT;
                    end
                    else if (overflow_reg)
                    begin
                        res_status_next = ST_OVERFLOW;
                        state_next      = S_EMIT;
                    end
                    else if (level_reg == '0)
                    begin
                        res_status_next = ST_COMPLETE;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        res_status_next = ST_INCOMPLETE;
                        state_next      = S_WALK;
                    end
                    level_next    = '0;
                    corrupt_next  = 1'b0;
                    overflow_next = 1'b0;
                    bad_next      = '0;
                end
                else if (accept && !corrupt_reg && !overflow_reg)
                begin
                    if (ch_open)
                    begin
                        if (level_reg == LVL_FULL)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            stk_wr.en  = 1'b1;
                            level_next = level_reg + LVL_ONE;
                        end
                    end
                    else if (ch_close && (level_reg != '0) && (top_kind == ch_close_kind))
                    begin
                        level_next = level_dec;
                    end
                    else
                    begin
                        corrupt_next = 1'b1;
                        bad_next     = char_code;
                    end
                end
            end

            S_WALK:
            begin
                acc_step      = 1'b1;
                walk_cnt_next = walk_dec;
                if (walk_cnt_reg == LVL_ONE)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            level_reg      <= '0;
            corrupt_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            bad_reg        <= '0;
            walk_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            corrupt_reg    <= corrupt_next;
            overflow_reg   <= overflow_next;
            bad_reg        <= bad_next;
            walk_cnt_reg   <= walk_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_err_reg    <= res_err_next;
        res_bad_reg    <= res_bad_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_err_reg    <= res_err_reg;
            out_comp_reg   <= (res_status_reg == ST_INCOMPLETE) ? acc : '0;
            out_bad_reg    <= res_bad_reg;
        end
    end

    assign result_valid     = out_valid_reg;
    assign status           = out_status_reg;
    assign error_score      = out_err_reg;
    assign completion_score = out_comp_reg;
    assign offending_char   = out_bad_reg;

    // at most one of the two line flags
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(corrupt_reg && overflow_reg))
        else $error("corrupt and overflow both set");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_FULL)
        else $error("stack level past depth");

    a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (walk_cnt_reg != '0))
        else $error("stack walk with nothing left");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_score_only_incomplete: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_INCOMPLETE)) |-> (completion_score == '0))
        else $error("completion score on a line that is not incomplete");

endmodule

`default_nettype wire

[verif/bnc_line_checker.sv]
// Checker for the bracket nesting checker: watches both channels, predicts each line's result
// and compares it with what the block returns. Depends on bnc_pkg.
`default_nettype none

module bnc_line_checker
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire logic                item_ready,
    input  wire logic [CHAR_W-1:0]   char_code,
    input  wire logic                line_end,
    input  wire logic                result_valid,
    input  wire logic                result_ready,
    input  wire logic [1:0]          status,
    input  wire logic [ERR_W-1:0]    error_score,
    input  wire logic [SCORE_W-1:0]  completion_score,
    input  wire logic [CHAR_W-1:0]   offending_char,
    output int                       mismatches,
    output int                       lines_open
);

    typedef struct packed {
        status_t             st;
        logic [ERR_W-1:0]    err;
        logic [SCORE_W-1:0]  comp;
        logic [CHAR_W-1:0]   bad;
    } verdict_t;

    kind_t             open_kinds [STACK_DEPTH];
    int                level;
    logic              corrupt;
    logic              overflowed;
    logic [CHAR_W-1:0] first_bad;
    verdict_t          verdicts_due [$];
    int                errs;

    // -1 when the character is not an opening bracket
    function automatic int opening_kind(input logic [CHAR_W-1:0] ch);
        int k;
        k = -1;
        if (ch == CH_LPAREN) k = int'(KIND_PAREN);
        if (ch == CH_LSQ)    k = int'(KIND_SQ);
        if (ch == CH_LBRACE) k = int'(KIND_BRACE);
        if (ch == CH_LANGLE) k = int'(KIND_ANGLE);
        return k;
    endfunction

    function automatic int closing_kind(input logic [CHAR_W-1:0] ch);
        int k;
        k = -1;
        if (ch == CH_RPAREN) k = int'(KIND_PAREN);
        if (ch == CH_RSQ)    k = int'(KIND_SQ);
        if (ch == CH_RBRACE) k = int'(KIND_BRACE);
        if (ch == CH_RANGLE) k = int'(KIND_ANGLE);
        return k;
    endfunction

    function automatic logic [ERR_W-1:0] penalty(input kind_t k);
        logic [ERR_W-1:0] p;
        case (k)
            KIND_PAREN: p = SCORE_PAREN;
            KIND_SQ:    p = SCORE_SQ;
            KIND_BRACE: p = SCORE_BRACE;
            default:    p = SCORE_ANGLE;
        endcase
        return p;
    endfunction

    // base-5 walk from the top of the stack, wrapped to the field width
    function automatic logic [SCORE_W-1:0] completion_of(input int n);
        logic [63:0] acc;
        int          i;
        acc = '0;
        for (i = n - 1; i >= 0; i--)
            acc = acc * 5 + 64'(open_kinds[i]) + 64'd1;
        return acc[SCORE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        verdict_t got;
        int       ok;
        int       ck;
        if (!rst_n)
        begin
            level      = 0;
            corrupt    = 1'b0;
            overflowed = 1'b0;
            first_bad  = '0;
            errs       = 0;
            verdicts_due.delete();
            mismatches <= 0;
            lines_open <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (!line_end)
                begin
                    // once a line is spoilt the rest of it is ignored
                    if (!corrupt && !overflowed)
                    begin
                        ok = opening_kind(char_code);
                        ck = closing_kind(char_code);
                        if (ok >= 0)
                        begin
                            if (level >= STACK_DEPTH)
                                overflowed = 1'b1;
                            else
                            begin
                                open_kinds[level] = kind_t'(ok);
                                level++;
                            end
                        end
                        else if (ck >= 0 && level > 0 && open_kinds[level-1] == kind_t'(ck))
                            level--;
                        else
                        begin
                            corrupt   = 1'b1;
                            first_bad = char_code;
                        end
                    end
                end
                else
                begin
                    want.err  = '0;
                    want.comp = '0;
                    want.bad  = '0;
                    if (corrupt)
                    begin
                        want.st  = ST_CORRUPTED;
                        ck       = closing_kind(first_bad);
                        if (ck >= 0)
                            want.err = penalty(kind_t'(ck));
                        want.bad = first_bad;
                    end
                    else if (overflowed)
                        want.st = ST_OVERFLOW;
                    else if (level == 0)
                        want.st = ST_COMPLETE;
                    else
                    begin
                        want.st   = ST_INCOMPLETE;
                        want.comp = completion_of(level);
                    end
                    verdicts_due = {verdicts_due, want};
                    level      = 0;
                    corrupt    = 1'b0;
                    overflowed = 1'b0;
                    first_bad  = '0;
                end
            end

            if (result_valid && result_ready)
            begin
                got.st   = status_t'(status);
                got.err  = error_score;
                got.comp = completion_score;
                got.bad  = offending_char;
                if (verdicts_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected result word: status %0d error_score %0d",
                                 got.st, got.err,
                                 " completion_score %0d offending_char %02h",
                                 got.comp, got.bad);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got.st != want.st || got.err != want.err ||
                        got.comp != want.comp || got.bad != want.bad)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("mismatch (exp/got): status %0d/%0d error_score %0d/%0d",
                                     want.st, got.st, want.err, got.err,
                                     " completion_score %0d/%0d offending_char %02h/%02h",
                                     want.comp, got.comp, want.bad, got.bad);
                    end
                end
            end

            mismatches <= errs;
            lines_open <= verdicts_due.size();
        end
    end

endmodule

`default_nettype wire

[verif/tb_bracket_nesting_checker.sv]
// Testbench top for the bracket nesting checker: drives directed and random lines, stalls the
// result side at random and gives the verdict. Depends on bnc_pkg, bnc_line_checker and the design top.
`default_nettype none

module tb_bracket_nesting_checker;
    import bnc_pkg::*;

    localparam int DEPTH       = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORD_TARGET = 720;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    wire                 item_ready;
    logic [CHAR_W-1:0]   char_code    = '0;
    logic                line_end     = 1'b0;
    wire                 result_valid;
    logic                result_ready = 1'b0;
    wire  [1:0]          status;
    wire  [ERR_W-1:0]    error_score;
    wire  [SCORE_W-1:0]  completion_score;
    wire  [CHAR_W-1:0]   offending_char;

    int   mismatches;
    int   lines_open;
    int   cycles     = 0;
    int   words_sent = 0;
    int   stall_left = 0;
    logic calm       = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bracket_nesting_checker #(
        .STACK_DEPTH (DEPTH)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .char_code        (char_code),
        .line_end         (line_end),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .status           (status),
        .error_score      (error_score),
        .completion_score (completion_score),
        .offending_char   (offending_char)
    );

    bnc_line_checker #(
        .STACK_DEPTH (DEPTH)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .char_code        (char_code),
        .line_end         (line_end),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .status           (status),
        .error_score      (error_score),
        .completion_score (completion_score),
        .offending_char   (offending_char),
        .mismatches       (mismatches),
        .lines_open       (lines_open)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: a fresh random stall, or none, after every accepted result
    always @(posedge clk or negedge rst_n)
    begin : sink
        int n;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (result_ready)
        begin
            if (result_valid)
            begin
                n = calm ? 0 : $urandom_range(0, 3);
                if (n != 0)
                begin
                    result_ready <= 1'b0;
                    stall_left   <= n;
                end
            end
        end
        else if (stall_left <= 1)
            result_ready <= 1'b1;
        else
            stall_left <= stall_left - 1;
    end

    function automatic logic [CHAR_W-1:0] open_char(input kind_t k);
        logic [CHAR_W-1:0] c;
        case (k)
            KIND_PAREN: c = CH_LPAREN;
            KIND_SQ:    c = CH_LSQ;
            KIND_BRACE: c = CH_LBRACE;
            default:    c = CH_LANGLE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] close_char(input kind_t k);
        logic [CHAR_W-1:0] c;
        case (k)
            KIND_PAREN: c = CH_RPAREN;
            KIND_SQ:    c = CH_RSQ;
            KIND_BRACE: c = CH_RBRACE;
            default:    c = CH_RANGLE;
        endcase
        return c;
    endfunction

    // half brackets, half arbitrary bytes
    function automatic logic [CHAR_W-1:0] pick_any();
        kind_t k;
        k = kind_t'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0)
            return CHAR_W'($urandom_range(0, 255));
        else if ($urandom_range(0, 1) == 0)
            return open_char(k);
        else
            return close_char(k);
    endfunction

    // returns at the edge where the word is taken; valid stays up if no gap follows
    task automatic push_word(input logic [CHAR_W-1:0] ch, input logic le);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        char_code  <= ch;
        line_end   <= le;
        do
            @(posedge clk);
        while (!item_ready);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_word(s[i], 1'b0);
        push_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_line();
        kind_t             open_q [$];
        logic [CHAR_W-1:0] chars [$];
        kind_t             kk;
        int                mode;
        int                i;
        calm = ($urandom_range(0, 5) == 0);
        mode = $urandom_range(0, 99);
        if (mode < 80)
        begin
            // legal walk, kept within the stack depth
            repeat ($urandom_range(0, 12))
            begin
                if (open_q.size() == 0 ||
                    (open_q.size() < DEPTH && $urandom_range(0, 1) == 1))
                begin
                    kk = kind_t'($urandom_range(0, 3));
                    open_q = {open_q, kk};
                    chars  = {chars, open_char(kk)};
                end
                else
                begin
                    kk = open_q[$];
                    open_q.delete(open_q.size() - 1);
                    chars = {chars, close_char(kk)};
                end
            end
        end
        if (mode < 35)
        begin
            while (open_q.size() != 0)
            begin
                kk = open_q[$];
                open_q.delete(open_q.size() - 1);
                chars = {chars, close_char(kk)};
            end
        end
        else if (mode < 60)
        begin
            // some lines go to the full depth for the largest scores
            if ($urandom_range(0, 4) == 0 || open_q.size() == 0)
            begin
                do
                begin
                    kk = kind_t'($urandom_range(0, 3));
                    open_q = {open_q, kk};
                    chars  = {chars, open_char(kk)};
                end
                while (open_q.size() < DEPTH && $urandom_range(0, 3) != 0);
            end
        end
        else if (mode < 80)
        begin
            i = $urandom_range(0, 2);
            if (i == 0 && open_q.size() != 0)
            begin
                kk = open_q[$];
                kk = kind_t'(kk + $urandom_range(1, 3));
                chars = {chars, close_char(kk)};
            end
            else if (i <= 1)
                chars = {chars, close_char(kind_t'($urandom_range(0, 3)))};
            else
                chars = {chars, CHAR_W'($urandom_range(0, 255))};
            repeat ($urandom_range(0, 4)) chars = {chars, pick_any()};
        end
        else if (mode < 88)
        begin
            repeat (DEPTH + $urandom_range(1, 2))
                chars = {chars, open_char(kind_t'($urandom_range(0, 3)))};
            repeat ($urandom_range(0, 4)) chars = {chars, pick_any()};
        end
        else
        begin
            repeat ($urandom_range(1, 8)) chars = {chars, pick_any()};
        end
        for (i = 0; i < chars.size(); i++)
            push_word(chars[i], 1'b0);
        push_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("");
        send_text(")");
        send_text("<]");
        send_text("{>");
        send_text("[}");
        send_text("(<>)");
        send_text("([{<");
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b1);

        while (words_sent < WORD_TARGET)
            random_line();
        item_valid <= 1'b0;

        @(posedge clk);
        while (lines_open != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatches == 0 && lines_open == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/bnc_pkg.sv
design/bnc_stack.sv
design/bnc_score_acc.sv
design/bracket_nesting_checker.sv
verif/bnc_line_checker.sv
verif/tb_bracket_nesting_checker.sv
